@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the tone generator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Check a condition at every clock edge outside reset.
`define MFSTG_ASSERT(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("mfstg: assertion failed");
// Check that a condition implies another in the same cycle.
`define MFSTG_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mfstg: assertion failed");
// Check that a condition implies another in the next cycle.
`define MFSTG_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mfstg: assertion failed");
`else
`define MFSTG_ASSERT(lbl, clk, rst_n, cond)
`define MFSTG_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define MFSTG_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

@@ hw/rtl/mfstg_pkg.sv @@
// Types, constants and table-building functions of the sine tone generator.
`default_nettype none
package mfstg_pkg;

  localparam int unsigned MaxChanDef   = 16;
  localparam int unsigned TableBitsDef = 12;
  localparam int unsigned PhaseBitsDef = 32;
  localparam int unsigned ChanCap      = 16;
  localparam int unsigned ChanIdxW     = 4;
  localparam int unsigned ChanCntW     = 5;
  localparam int unsigned QueueDepth   = 2;
  localparam int unsigned SampleW      = 32;
  localparam int unsigned StepW        = 32;
  localparam int unsigned MagW         = 30;
  localparam int unsigned FloatMagW    = 31;

  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] RegPhaseStep = 2'd0;
  localparam logic [CfgIdxW-1:0] RegChanCount = 2'd1;
  localparam logic [CfgIdxW-1:0] RegSampleFmt = 2'd2;

  typedef enum logic [2:0] {
    FmtS8    = 3'd0,
    FmtS16Le = 3'd1,
    FmtS16Be = 3'd2,
    FmtF32   = 3'd3,
    FmtS32Le = 3'd4,
    FmtS32Be = 3'd5
  } fmt_e;

  // Per-frame control handed from front to back.
  typedef struct packed {
    fmt_e                fmt;
    logic [ChanIdxW-1:0] chan_last;
    logic                first_half;
  } frame_ctl_t;

  localparam logic [63:0] Q30One    = 64'd1 << 30;
  localparam logic [63:0] HalfPiQ30 = 64'd1686629713;
  localparam logic [63:0] AmpInt    = 64'h3FFF_FFFF;
  localparam logic [63:0] HornerDiv [6] = '{64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6};

  // sin(pi/2 * a / 2^(tb-2)) in unsigned Q30, evaluated at elaboration
  function automatic logic [63:0] quarter_sine(int unsigned a, int unsigned tb);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    x  = (HalfPiQ30 * 64'(a)) >> (tb - 2);
    x2 = (x * x) >> 30;
    t  = Q30One;
    for (int i = 0; i < 6; i++) begin
      t = Q30One - (((x2 * t) >> 30) / HornerDiv[i]);
    end
    s = (x * t) >> 30;
    return (s > Q30One) ? Q30One : s;
  endfunction

  // float32 exponent and mantissa of m / 2^32, round to nearest even, sign left out
  function automatic logic [FloatMagW-1:0] float_mag(logic [63:0] m);
    int unsigned p;
    int unsigned sh;
    int unsigned bexp;
    logic [63:0] mant;
    logic [63:0] rem;
    logic [63:0] half;
    p = 0;
    if (m == 64'd0) begin
      return '0;
    end
    for (int j = 1; j < 64; j++) begin
      if ((m >> j) != 64'd0) p = j;
    end
    if (p <= 23) begin
      mant = m << (23 - p);
    end else begin
      sh   = p - 23;
      rem  = m & ((64'd1 << sh) - 64'd1);
      half = 64'd1 << (sh - 1);
      mant = m >> sh;
      if (rem > half || (rem == half && mant[0])) mant = mant + 64'd1;
    end
    bexp = p + 95;
    if (mant == (64'd1 << 24)) begin
      mant = mant >> 1;
      bexp = bexp + 1;
    end
    return {8'(bexp), mant[22:0]};
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/mfstg_front.sv @@
// Front end: configuration registers, phase accumulator and frame classification.
`default_nettype none
module mfstg_front #(
  parameter int unsigned MaxChan   = 16,
  parameter int unsigned TableBits = 12,
  parameter int unsigned PhaseBits = 32
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire  [mfstg_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  wire  [mfstg_pkg::StepW-1:0]        cfg_data_i,
  input  wire                                in_valid_i,
  output logic                               in_ready_o,
  input  wire                                frame_request_i,
  output logic                               enq_valid_o,
  input  wire                                enq_ready_i,
  output mfstg_pkg::frame_ctl_t              enq_ctl_o,
  output logic [TableBits-2:0]               enq_addr_o
);
  import mfstg_pkg::*;

  localparam int unsigned ChanLimit = (MaxChan < ChanCap) ? MaxChan : ChanCap;
  localparam logic [TableBits-2:0] Quarter = (TableBits-1)'(1) << (TableBits - 2);

  logic [StepW-1:0]     step_q;
  logic [ChanCntW-1:0]  chan_cnt_q;
  logic [2:0]           fmt_q;
  logic [PhaseBits-1:0] accum_q, accum_d;

  logic                 accept;
  logic                 fmt_ok;
  logic [TableBits-1:0] k;
  logic [TableBits-3:0] r;
  logic [ChanCntW-1:0]  nch;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q     <= '0;
      chan_cnt_q <= ChanCntW'(1);
      fmt_q      <= 3'(FmtS16Le);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegPhaseStep: step_q     <= cfg_data_i;
        RegChanCount: chan_cnt_q <= cfg_data_i[ChanCntW-1:0];
        RegSampleFmt: fmt_q      <= cfg_data_i[2:0];
        default:      ;
      endcase
    end
  end

  assign in_ready_o = enq_ready_i;
  assign accept     = in_valid_i && in_ready_o && frame_request_i;
  assign fmt_ok     = (fmt_q <= 3'(FmtS32Be));

  // advance the phase on every real request, even when the format is unknown
  assign accum_d = accum_q + step_q[PhaseBits-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accum_q <= '0;
    end else if (accept) begin
      accum_q <= accum_d;
    end
  end

  // fold the phase into the first quadrant of the table
  assign k = accum_q[PhaseBits-1 -: TableBits];
  assign r = k[TableBits-3:0];
  assign enq_addr_o = k[TableBits-2] ? (Quarter - {1'b0, r}) : {1'b0, r};

  always_comb begin
    nch = chan_cnt_q;
    if (chan_cnt_q == '0) nch = ChanCntW'(1);
    if (nch > ChanCntW'(ChanLimit)) nch = ChanCntW'(ChanLimit);
  end

  assign enq_ctl_o.fmt        = fmt_e'(fmt_q);
  assign enq_ctl_o.chan_last  = ChanIdxW'(nch - ChanCntW'(1));
  assign enq_ctl_o.first_half = ~k[TableBits-1];
  assign enq_valid_o          = in_valid_i && frame_request_i && fmt_ok;

endmodule
`default_nettype wire

@@ hw/rtl/mfstg_queue.sv @@
// Short queue of frame descriptors between front and back.
`default_nettype none
`include "assert_macros.svh"
module mfstg_queue #(
  parameter int unsigned DataW = 16,
  parameter int unsigned Depth = 2
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               wr_valid_i,
  output logic              wr_ready_o,
  input  wire  [DataW-1:0]  wr_data_i,
  output logic              rd_valid_o,
  input  wire               rd_ready_i,
  output logic [DataW-1:0]  rd_data_o
);
  import mfstg_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [DataW-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             wr, rd;

  assign wr_ready_o = (cnt_q != CntW'(Depth));
  assign rd_valid_o = (cnt_q != '0);
  assign wr         = wr_valid_i && wr_ready_o;
  assign rd         = rd_valid_o && rd_ready_i;
  assign rd_data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wr_ptr_q] <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr) wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      if (rd) rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      if (wr && !rd) cnt_q <= cnt_q + CntW'(1);
      else if (rd && !wr) cnt_q <= cnt_q - CntW'(1);
    end
  end

  `MFSTG_ASSERT(a_cnt_bound, clk_i, rst_ni, cnt_q <= CntW'(Depth))
  `MFSTG_ASSERT_NXT(a_drain_last, clk_i, rst_ni, rd && !wr && cnt_q == CntW'(1), !rd_valid_o)

endmodule
`default_nettype wire

@@ hw/rtl/mfstg_back.sv @@
// Back end: sine table read, sample formatting and per-channel emission.
`default_nettype none
`include "assert_macros.svh"
module mfstg_back #(
  parameter int unsigned TableBits = 12
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 deq_valid_i,
  output logic                                deq_ready_o,
  input  mfstg_pkg::frame_ctl_t               deq_ctl_i,
  input  wire  [TableBits-2:0]                deq_addr_i,
  output logic                                empty_o,
  input  wire                                 pop_i,
  output logic [mfstg_pkg::SampleW-1:0]       sample_bits_o,
  output logic [mfstg_pkg::ChanIdxW-1:0]      channel_index_o,
  output logic                                last_of_frame_o
);
  import mfstg_pkg::*;

  localparam int unsigned RomDepth = (1 << (TableBits - 2)) + 1;
  localparam int unsigned RomW     = 1 + FloatMagW + MagW;

  typedef logic [RomW-1:0] rom_arr_t [RomDepth];

  // entry: {nonzero, float32 magnitude of 0.75*sin, integer magnitude}
  function automatic rom_arr_t build_rom();
    rom_arr_t    rom;
    logic [63:0] s;
    logic [63:0] mag;
    for (int a = 0; a < RomDepth; a++) begin
      s      = quarter_sine(a, TableBits);
      mag    = (s * AmpInt) >> 30;
      rom[a] = {(s != 64'd0), float_mag(s * 64'd3), mag[MagW-1:0]};
    end
    return rom;
  endfunction

  localparam rom_arr_t Rom = build_rom();

  logic                rd_valid_q;
  frame_ctl_t          rd_ctl_q;
  logic [RomW-1:0]     rom_q;
  logic                rd_adv, deq, load;

  logic                act_q;
  logic [SampleW-1:0]  bits_q, bits_d;
  logic [ChanIdxW-1:0] cnt_q;
  logic [ChanIdxW-1:0] last_idx_q;
  logic                last;

  logic                nz, neg;
  logic [FloatMagW-1:0] fmag;
  logic [SampleW-1:0]  mag, word;

  assign last   = (cnt_q == last_idx_q);
  assign load   = rd_valid_q && (!act_q || (pop_i && last));
  assign rd_adv = !rd_valid_q || load;
  assign deq    = rd_adv && deq_valid_i;
  assign deq_ready_o = rd_adv;

  always_ff @(posedge clk_i) begin
    if (deq) begin
      rom_q    <= Rom[deq_addr_i];
      rd_ctl_q <= deq_ctl_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q <= 1'b0;
    end else if (rd_adv) begin
      rd_valid_q <= deq_valid_i;
    end
  end

  assign nz   = rom_q[RomW-1];
  assign fmag = rom_q[MagW +: FloatMagW];
  assign mag  = SampleW'(rom_q[MagW-1:0]);
  // -sin is negative over the first half turn
  assign neg  = rd_ctl_q.first_half && nz;
  assign word = neg ? (SampleW'(0) - mag) : mag;

  always_comb begin
    unique case (rd_ctl_q.fmt)
      FmtS8:    bits_d = {24'd0, word[31:24]};
      FmtS16Le: bits_d = {16'd0, word[31:16]};
      FmtS16Be: bits_d = {16'd0, word[23:16], word[31:24]};
      FmtF32:   bits_d = {neg, fmag};
      FmtS32Le: bits_d = word;
      FmtS32Be: bits_d = {word[7:0], word[15:8], word[23:16], word[31:24]};
      default:  bits_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      bits_q     <= bits_d;
      last_idx_q <= rd_ctl_q.chan_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
      cnt_q <= '0;
    end else if (load) begin
      act_q <= 1'b1;
      cnt_q <= '0;
    end else if (act_q && pop_i) begin
      // drop the frame after its last word, otherwise advance the channel
      if (last) act_q <= 1'b0;
      else cnt_q <= cnt_q + ChanIdxW'(1);
    end
  end

  assign empty_o         = !act_q;
  assign sample_bits_o   = bits_q;
  assign channel_index_o = cnt_q;
  assign last_of_frame_o = last;

  `MFSTG_ASSERT_NXT(a_load_first, clk_i, rst_ni, load, act_q && cnt_q == '0)
  `MFSTG_ASSERT_IMP(a_cnt_range, clk_i, rst_ni, act_q, cnt_q <= last_idx_q)
  `MFSTG_ASSERT_NXT(a_mid_frame, clk_i, rst_ni, act_q && pop_i && !last, act_q)

endmodule
`default_nettype wire

@@ hw/rtl/multi_format_sine_tone_generator_core.sv @@
// Sine tone generator: each frame request yields one formatted sample per channel.
//
// Input queue: raise push with frame_request_i while full is low; a request of 0
// is taken and dropped. A request of 1 advances the phase by phase_step and, for a
// known sample format, queues one frame. Result queue: while empty is low the
// current word (sample_bits_o, channel_index_o, last_of_frame_o) is on the ports;
// pop takes it. A frame gives channel_count words (0 counts as 1, at most MaxChan
// and 16), one per cycle while pop is high, the last flagged. A frame's first word
// passes the frame queue, the table read register and the output register. The
// output word register and a table read stage are refilled in the cycle the last
// word of a frame is taken, so frames follow without gaps. A single-ported
// constant sine table with registered read sits in the back end.
// When pop stays low the frame in the output register holds, the table stage and
// a two-entry frame queue fill, and then full rises.
// Configuration: write cfg_index_i / cfg_data_i with cfg_valid_i (ready always
// high), only while no frame is pending. Reset clears the phase and all queues and
// sets phase_step 0, channel_count 1, sample_format S16 little endian.
`default_nettype none
module multi_format_sine_tone_generator_core #(
  parameter int unsigned MaxChan   = mfstg_pkg::MaxChanDef,
  parameter int unsigned TableBits = mfstg_pkg::TableBitsDef,
  parameter int unsigned PhaseBits = mfstg_pkg::PhaseBitsDef
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire  [mfstg_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  wire  [mfstg_pkg::StepW-1:0]      cfg_data_i,
  input  wire                              push,
  output logic                             full,
  input  wire                              frame_request_i,
  output logic                             empty,
  input  wire                              pop,
  output logic [mfstg_pkg::SampleW-1:0]    sample_bits_o,
  output logic [mfstg_pkg::ChanIdxW-1:0]   channel_index_o,
  output logic                             last_of_frame_o
);
  import mfstg_pkg::*;

  localparam int unsigned AddrW = TableBits - 1;
  localparam int unsigned EntW  = $bits(frame_ctl_t) + AddrW;

  logic              in_ready;
  logic              enq_valid, enq_ready;
  frame_ctl_t        enq_ctl, deq_ctl;
  logic [AddrW-1:0]  enq_addr, deq_addr;
  logic              deq_valid, deq_ready;
  logic [EntW-1:0]   deq_data;

  mfstg_front #(
    .MaxChan   (MaxChan),
    .TableBits (TableBits),
    .PhaseBits (PhaseBits)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (push),
    .in_ready_o      (in_ready),
    .frame_request_i (frame_request_i),
    .enq_valid_o     (enq_valid),
    .enq_ready_i     (enq_ready),
    .enq_ctl_o       (enq_ctl),
    .enq_addr_o      (enq_addr)
  );

  assign full = !in_ready;

  mfstg_queue #(
    .DataW (EntW),
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (enq_valid),
    .wr_ready_o (enq_ready),
    .wr_data_i  ({enq_ctl, enq_addr}),
    .rd_valid_o (deq_valid),
    .rd_ready_i (deq_ready),
    .rd_data_o  (deq_data)
  );

  assign deq_ctl  = frame_ctl_t'(deq_data[EntW-1:AddrW]);
  assign deq_addr = deq_data[AddrW-1:0];

  mfstg_back #(
    .TableBits (TableBits)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .deq_valid_i     (deq_valid),
    .deq_ready_o     (deq_ready),
    .deq_ctl_i       (deq_ctl),
    .deq_addr_i      (deq_addr),
    .empty_o         (empty),
    .pop_i           (pop),
    .sample_bits_o   (sample_bits_o),
    .channel_index_o (channel_index_o),
    .last_of_frame_o (last_of_frame_o)
  );

endmodule
`default_nettype wire

@@ verif/multi_format_sine_tone_generator_core_tb.sv @@
// Self-checking testbench for the multi-format sine tone generator core.
`timescale 1ns / 100ps
module tb;
  import mfstg_pkg::*;

  localparam logic [CfgIdxW-1:0] RegSpare = 2'd3;
  localparam logic [2:0] FmtRsvd6 = 3'd6;
  localparam logic [2:0] FmtRsvd7 = 3'd7;
  localparam logic [63:0] QOne       = 64'd1 << 30;
  localparam logic [63:0] SineHalfPi = 64'd1686629713;
  localparam logic [63:0] AmpQ30     = 64'h3FFF_FFFF;
  localparam int StallLimit  = 2000;
  localparam int ItemTarget  = 210;
  localparam int LongHold    = 200;

  typedef struct packed {
    logic [31:0] bits;
    logic [3:0]  chan;
    logic        last;
  } tone_word_t;

  class tone_scoreboard;
    logic [31:0] step_r;
    logic [4:0]  count_r;
    logic [2:0]  fmt_r;
    logic [31:0] phase_r;
    tone_word_t  due_words[$];
    int          failures;

    function new();
      step_r   = '0;
      count_r  = 5'd1;
      fmt_r    = FmtS16Le;
      phase_r  = '0;
      failures = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [31:0] data);
      case (idx)
        RegPhaseStep: step_r = data;
        RegChanCount: count_r = data[4:0];
        RegSampleFmt: fmt_r = data[2:0];
        default: ;
      endcase
    endfunction

    // Quarter-wave sine in unsigned Q30, Horner form with truncated products
    function logic [63:0] sine_q30(logic [10:0] a);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] s;
      logic [63:0] d;
      int n;
      x  = (SineHalfPi * 64'(a)) >> 10;
      x2 = (x * x) >> 30;
      t  = QOne;
      for (n = 6; n >= 1; n--) begin
        d = 64'(2 * n * (2 * n + 1));
        t = QOne - (((x2 * t) >> 30) / d);
      end
      s = (x * t) >> 30;
      return (s > QOne) ? QOne : s;
    endfunction

    // m / 2^32 as float32, round to nearest even
    function logic [31:0] float_word(logic [63:0] m, bit neg);
      logic [63:0] mant;
      logic [63:0] rem;
      logic [63:0] half;
      logic [7:0]  bexp;
      int p;
      int sh;
      int j;
      if (m == 64'd0) return 32'd0;
      p = 0;
      for (j = 0; j < 64; j++) begin
        if (m[j]) p = j;
      end
      if (p <= 23) begin
        mant = m << (23 - p);
      end else begin
        sh   = p - 23;
        rem  = m & ((64'd1 << sh) - 64'd1);
        half = 64'd1 << (sh - 1);
        mant = m >> sh;
        if (rem > half || (rem == half && mant[0])) mant = mant + 64'd1;
      end
      bexp = 8'(p + 95);
      if (mant == (64'd1 << 24)) begin
        mant = mant >> 1;
        bexp = bexp + 8'd1;
      end
      return {neg, bexp, mant[22:0]};
    endfunction

    function void take_frame(bit req);
      logic [31:0] ph;
      logic [31:0] mag;
      logic [31:0] word;
      logic [31:0] bits;
      logic [11:0] k;
      logic [10:0] a;
      logic [63:0] s;
      bit neg;
      int nch;
      tone_word_t w;
      if (!req) return;
      ph = phase_r;
      phase_r = phase_r + step_r;
      // phase still advances on a reserved format, but nothing comes out
      if (fmt_r > FmtS32Be) return;
      k = ph[31:20];
      a = k[10] ? 11'd1024 - k[9:0] : {1'b0, k[9:0]};
      s = sine_q30(a);
      neg = (k[11] == 1'b0) && (s != 64'd0);
      mag = 32'((s * AmpQ30) >> 30);
      word = neg ? -mag : mag;
      case (fmt_r)
        FmtS8:    bits = {24'd0, word[31:24]};
        FmtS16Le: bits = {16'd0, word[31:16]};
        FmtS16Be: bits = {16'd0, word[23:16], word[31:24]};
        FmtF32:   bits = float_word(s * 64'd3, neg);
        FmtS32Le: bits = word;
        default:  bits = {word[7:0], word[15:8], word[23:16], word[31:24]};
      endcase
      nch = (count_r == 5'd0) ? 1 : ((count_r > 5'd16) ? 16 : int'(count_r));
      for (int c = 0; c < nch; c++) begin
        w.bits = bits;
        w.chan = 4'(c);
        w.last = (c == nch - 1);
        due_words.push_back(w);
      end
    endfunction

    function int words_due();
      return due_words.size();
    endfunction

    function void check_word(logic [31:0] bits, logic [3:0] chan, logic last);
      tone_word_t want;
      if (due_words.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected word: bits %h chan %0d last %0b", bits, chan, last);
        return;
      end
      want = due_words.pop_front();
      if (want.bits !== bits || want.chan !== chan || want.last !== last) begin
        failures++;
        if (failures <= 10)
          $display("word mismatch: want bits %h chan %0d last %0b, got bits %h chan %0d last %0b",
                   want.bits, want.chan, want.last, bits, chan, last);
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [StepW-1:0]    cfg_data;
  logic                push;
  logic                full;
  logic                frame_request;
  logic                empty;
  logic                pop;
  logic [SampleW-1:0]  sample_bits;
  logic [ChanIdxW-1:0] channel_index;
  logic                last_of_frame;

  tone_scoreboard sb;
  bit hold_req = 1'b0;
  int frames_sent = 0;
  int send_free_left = 0;
  int idle_cycles = 0;

  multi_format_sine_tone_generator_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .push            (push),
    .full            (full),
    .frame_request_i (frame_request),
    .empty           (empty),
    .pop             (pop),
    .sample_bits_o   (sample_bits),
    .channel_index_o (channel_index),
    .last_of_frame_o (last_of_frame)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // Reset the stall count on reset or any handshake; stop with an error at StallLimit
  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("[multi_format_sine_tone_generator_core] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: random stalls, free-running stretches and a long hold on each request
  initial begin : sink
    int stall_left;
    int free_left;
    int roll;
    stall_left = 0;
    free_left = 0;
    pop = 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (pop && !empty) sb.check_word(sample_bits, channel_index, last_of_frame);
      if (hold_req) begin
        hold_req = 1'b0;
        stall_left = LongHold;
        free_left = 0;
      end else if (stall_left == 0 && free_left == 0) begin
        roll = $urandom_range(0, 99);
        if (roll < 20) stall_left = $urandom_range(1, 3);
        else if (roll < 23) stall_left = $urandom_range(20, 60);
        else if (roll < 28) free_left = $urandom_range(50, 150);
      end
      if (free_left > 0) begin
        free_left--;
        pop <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  function automatic int sender_gap();
    int roll;
    if (send_free_left > 0) begin
      send_free_left--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 89) return $urandom_range(20, 50);
    if (roll < 95) begin
      send_free_left = $urandom_range(20, 60);
      return 0;
    end
    return $urandom_range(4, 8);
  endfunction

  task automatic push_frame(input bit req, input int gap);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push <= 1'b1;
    frame_request <= req;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    sb.take_frame(req);
    frames_sent++;
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    sb.write_reg(idx, data);
  endtask

  // Drop push, wait for every expected word, then let a dropped frame drain
  task automatic settle();
    push <= 1'b0;
    while (sb.words_due() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic run_tone(input logic [31:0] stp, input logic [4:0] cnt,
                          input logic [2:0] fmt, input int frames, input bit hold,
                          input int zero_pct);
    write_reg(RegPhaseStep, stp);
    write_reg(RegChanCount, {27'd0, cnt});
    write_reg(RegSampleFmt, {29'd0, fmt});
    cfg_valid <= 1'b0;
    if (hold) hold_req = 1'b1;
    for (int i = 0; i < frames; i++) begin
      push_frame($urandom_range(0, 99) >= zero_pct, sender_gap());
    end
    settle();
  endtask

  initial begin : stimulus
    logic [31:0] stp;
    logic [4:0]  cnt;
    logic [2:0]  fmt;
    int roll;
    int phase_no;
    sb = new();
    rst_ni = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    push = 1'b0;
    frame_request = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: zero step, one channel, S16 little endian
    push_frame(1'b1, 0);
    push_frame(1'b0, 0);
    push_frame(1'b1, 2);
    settle();
    // quadrant boundaries at full width, receiver held off to fill the block
    run_tone(32'h4000_0000, 5'd16, FmtS32Le, 5, 1'b1, 0);
    run_tone(32'hFFFF_FFFF, 5'd31, FmtF32, 3, 1'b0, 0);
    run_tone(32'h1000_0000, 5'd2, FmtS8, 4, 1'b0, 0);
    write_reg(RegSpare, 32'hFFFF_FFFF);
    run_tone(32'h0010_0000, 5'd0, FmtS16Be, 3, 1'b0, 0);
    run_tone(32'h0800_0000, 5'd3, FmtRsvd6, 2, 1'b0, 0);
    run_tone(32'h0800_0000, 5'd3, FmtRsvd7, 1, 1'b0, 0);
    run_tone(32'h2000_0000, 5'd4, FmtS32Be, 3, 1'b0, 0);
    run_tone(32'h0400_0000, 5'd1, FmtS16Le, 2, 1'b0, 0);

    phase_no = 0;
    while (frames_sent < ItemTarget) begin
      roll = $urandom_range(0, 9);
      if (roll < 5) stp = $urandom;
      else if (roll == 5) stp = $urandom_range(1, 32'h0010_0000);
      else if (roll == 6) stp = $urandom & 32'hFFF0_0000;
      else if (roll == 7) stp = 32'd0;
      else if (roll == 8) stp = 32'hFFFF_FFFF;
      else stp = {2'($urandom_range(0, 3)), 30'd0} + $urandom_range(0, 2) - 32'd1;
      roll = $urandom_range(0, 9);
      if (roll < 5) cnt = 5'($urandom_range(1, 4));
      else if (roll < 8) cnt = 5'($urandom_range(0, 31));
      else cnt = 5'($urandom_range(5, 16));
      if ($urandom_range(0, 9) == 0) fmt = 3'($urandom_range(FmtRsvd6, FmtRsvd7));
      else fmt = 3'($urandom_range(FmtS8, FmtS32Be));
      if ($urandom_range(0, 9) == 0) write_reg(RegSpare, $urandom);
      if (phase_no == 0) begin
        run_tone(stp, 5'd16, FmtS16Le, 16, 1'b1, 10);
      end else begin
        run_tone(stp, cnt, fmt, $urandom_range(4, 16), 1'b0, 10);
      end
      phase_no++;
    end

    push <= 1'b0;
    while (sb.words_due() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.failures == 0 && sb.words_due() == 0) begin
      $display("[multi_format_sine_tone_generator_core] OK");
    end else begin
      $display("[multi_format_sine_tone_generator_core] ERROR");
    end
    $finish;
  end

endmodule

@@ multi_format_sine_tone_generator_core.f @@
+incdir+hw/rtl
hw/rtl/mfstg_pkg.sv
hw/rtl/mfstg_front.sv
hw/rtl/mfstg_queue.sv
hw/rtl/mfstg_back.sv
hw/rtl/multi_format_sine_tone_generator_core.sv
verif/multi_format_sine_tone_generator_core_tb.sv
